>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the receive dispatcher modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/crdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdr_pkg
// Types and constants shared by the receive dispatcher front, queue and back.
// ----------------------------------------------------------------------------
package crdr_pkg;

  // Field widths
  localparam int ID_W       = 11;
  localparam int LEN_W      = 4;
  localparam int WORD_W     = 64;
  localparam int BEAT_W     = 3;
  localparam int FILL_W     = 4;
  localparam int SPEED_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Command queue geometry
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = QPTR_W + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_SECOND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_THIRD   = 3'd4;

  // Configuration reset values
  localparam logic [ID_W-1:0] RST_RANGE_LOW  = 11'h100;
  localparam logic [ID_W-1:0] RST_RANGE_HIGH = 11'h1FF;
  localparam logic [ID_W-1:0] RST_ID_FIRST   = 11'h100;
  localparam logic [ID_W-1:0] RST_ID_SECOND  = 11'h110;
  localparam logic [ID_W-1:0] RST_ID_THIRD   = 11'h120;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_BEAT   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  // Command operations
  typedef enum logic [1:0] {
    OP_BEAT  = 2'd0,
    OP_FINAL = 2'd1,
    OP_POP   = 2'd2
  } op_t;

  // Frame classes decided at the front
  typedef enum logic [2:0] {
    CLS_DIAG    = 3'd0,
    CLS_DISCARD = 3'd1,
    CLS_FIRST   = 3'd2,
    CLS_SECOND  = 3'd3,
    CLS_THIRD   = 3'd4
  } cls_t;

  // One classified command from front to back
  typedef struct packed {
    op_t                op;
    cls_t               cls;
    logic [BEAT_W-1:0]  beat;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [WORD_W-1:0]  word;
    logic [SPEED_W-1:0] speed_bits;
  } cmd_t;

endpackage

>>> design/crdr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdr_front
// Accepts input items, tracks the beat position and classifies final beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crdr_front import crdr_pkg::*; #(
  parameter int BEATS_PER_FRAME = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [ID_W-1:0]       in_frame_id,
  input  logic [LEN_W-1:0]      in_frame_len_code,
  input  logic [WORD_W-1:0]     in_frame_word,
  input  logic                  in_frame_end,
  output logic                  enq_valid,
  input  logic                  enq_ready,
  output cmd_t                  enq_cmd
);

  logic [ID_W-1:0]    range_low_r, range_high_r, id_first_r, id_second_r, id_third_r;
  logic [BEAT_W-1:0]  beat_r, beat_nxt;
  logic [SPEED_W-1:0] first_lo_r;
  logic               accept;
  logic               is_final;
  logic               in_range;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RST_RANGE_LOW;
      range_high_r <= RST_RANGE_HIGH;
      id_first_r   <= RST_ID_FIRST;
      id_second_r  <= RST_ID_SECOND;
      id_third_r   <= RST_ID_THIRD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        CFG_RANGE_HIGH: range_high_r <= cfg_data;
        CFG_ID_FIRST:   id_first_r   <= cfg_data;
        CFG_ID_SECOND:  id_second_r  <= cfg_data;
        CFG_ID_THIRD:   id_third_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready  = enq_ready;
  assign enq_valid = in_valid;
  assign accept    = in_valid && enq_ready;

  assign is_final = in_frame_end || (beat_r == BEAT_W'(BEATS_PER_FRAME - 1));
  assign in_range = (range_low_r <= in_frame_id) && (in_frame_id <= range_high_r);

  // Classify the item into a command
  always_comb begin
    enq_cmd            = '0;
    enq_cmd.beat       = beat_r;
    enq_cmd.id         = in_frame_id;
    enq_cmd.len        = in_frame_len_code;
    enq_cmd.word       = in_frame_word;
    enq_cmd.speed_bits = (beat_r == '0) ? in_frame_word[SPEED_W-1:0] : first_lo_r;
    if (in_req_type) begin
      enq_cmd.op = OP_POP;
    end else if (is_final) begin
      enq_cmd.op = OP_FINAL;
    end else begin
      enq_cmd.op = OP_BEAT;
    end
    if (!in_range) begin
      enq_cmd.cls = CLS_DIAG;
    end else if (in_frame_id == id_first_r) begin
      enq_cmd.cls = CLS_FIRST;
    end else if (in_frame_id == id_second_r) begin
      enq_cmd.cls = CLS_SECOND;
    end else if (in_frame_id == id_third_r) begin
      enq_cmd.cls = CLS_THIRD;
    end else begin
      enq_cmd.cls = CLS_DISCARD;
    end
  end

  // Advance the beat position on frame beats, wrap on the final beat
  always_comb begin
    beat_nxt = beat_r;
    if (accept && !in_req_type) begin
      beat_nxt = is_final ? '0 : beat_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  // Hold the low word of the first beat for speed messages
  always_ff @(posedge clk) begin
    if (accept && !in_req_type && (beat_r == '0)) begin
      first_lo_r <= in_frame_word[SPEED_W-1:0];
    end
  end

  `ASSERT_NEXT(a_final_wraps_beat, clk, rst_n, accept && enq_cmd.op == OP_FINAL, beat_r == '0)

endmodule

>>> design/crdr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdr_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crdr_queue import crdr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic enq_valid,
  output logic enq_ready,
  input  cmd_t enq_cmd,
  output logic deq_valid,
  input  logic deq_ready,
  output cmd_t deq_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push, pop;

  assign enq_ready = (count_r != QCNT_W'(QDEPTH));
  assign deq_valid = (count_r != '0);
  assign deq_cmd   = slots[rd_ptr_r];
  assign push      = enq_valid && enq_ready;
  assign pop       = deq_valid && deq_ready;

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= enq_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_IMPLY(a_q_no_underflow, clk, rst_n, deq_ready, count_r != '0)
  `ASSERT_NEXT(a_q_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

>>> design/crdr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdr_back
// Executes commands: ring memory writes, commits, speed latches and pops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crdr_back import crdr_pkg::*; #(
  parameter int RING_DEPTH      = 16,
  parameter int BEATS_PER_FRAME = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [ID_W-1:0]    out_entry_id,
  output logic [LEN_W-1:0]   out_entry_len_code,
  output logic [WORD_W-1:0]  out_entry_word,
  output logic               out_last_beat,
  output logic [FILL_W-1:0]  out_fill_count,
  output logic               out_frame_dropped,
  output logic [SPEED_W-1:0] out_speed_first_bits,
  output logic [SPEED_W-1:0] out_speed_second_bits,
  output logic [SPEED_W-1:0] out_speed_third_bits
);

  localparam int SW     = $clog2(RING_DEPTH);
  localparam int WDEPTH = RING_DEPTH * BEATS_PER_FRAME;
  localparam int AW     = $clog2(WDEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [BEAT_W-1:0] last;
  } meta_t;

  // Ring storage
  logic [WORD_W-1:0] word_mem [WDEPTH];
  meta_t             meta_mem [RING_DEPTH];

  state_t             state_r, state_nxt;
  logic [SW-1:0]      ws_r, ws_nxt, rs_r, rs_nxt, pop_slot_r, pop_slot_nxt;
  logic [SW-1:0]      ws_inc, rs_inc, rd_slot;
  logic [BEAT_W-1:0]  k_r, k_nxt, rd_beat;
  logic [SPEED_W-1:0] spd0_r, spd0_nxt, spd1_r, spd1_nxt, spd2_r, spd2_nxt;
  logic               full, empty, out_free;
  logic               mem_we, meta_we, rd_en, meta_rd;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [WORD_W-1:0]  rd_word_r;
  meta_t              rd_meta_r;
  logic [SW:0]        ws_ext, rs_ext, fill_w;
  logic [SW+FILL_W-1:0] fill_ext;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               load_out;
  kind_t              ld_kind, out_kind_r;
  logic [ID_W-1:0]    ld_id, out_id_r;
  logic [LEN_W-1:0]   ld_len, out_len_r;
  logic [WORD_W-1:0]  ld_word, out_word_r;
  logic               ld_last, out_last_r;
  logic               ld_dropped, out_dropped_r;
  logic [FILL_W-1:0]  out_fill_r;

  assign ws_inc   = (ws_r == SW'(RING_DEPTH - 1)) ? '0 : ws_r + 1'b1;
  assign rs_inc   = (rs_r == SW'(RING_DEPTH - 1)) ? '0 : rs_r + 1'b1;
  assign full     = (ws_inc == rs_r);
  assign empty    = (ws_r == rs_r);
  assign out_free = !out_valid_r || out_ready;

  assign wr_addr = AW'(ws_r) * AW'(BEATS_PER_FRAME) + AW'(cmd.beat);
  assign rd_addr = AW'(rd_slot) * AW'(BEATS_PER_FRAME) + AW'(rd_beat);

  // Sequence commands
  always_comb begin
    state_nxt    = state_r;
    ws_nxt       = ws_r;
    rs_nxt       = rs_r;
    pop_slot_nxt = pop_slot_r;
    k_nxt        = k_r;
    spd0_nxt     = spd0_r;
    spd1_nxt     = spd1_r;
    spd2_nxt     = spd2_r;
    cmd_ready    = 1'b0;
    mem_we       = 1'b0;
    meta_we      = 1'b0;
    rd_en        = 1'b0;
    meta_rd      = 1'b0;
    rd_slot      = pop_slot_r;
    rd_beat      = k_r + 1'b1;
    load_out     = 1'b0;
    ld_kind      = KIND_STATUS;
    ld_id        = '0;
    ld_len       = '0;
    ld_word      = '0;
    ld_last      = 1'b1;
    ld_dropped   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_BEAT: begin
              cmd_ready = 1'b1;
              mem_we    = 1'b1;
            end
            OP_FINAL: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                mem_we    = 1'b1;
                load_out  = 1'b1;
                case (cmd.cls)
                  CLS_DIAG: begin
                    if (full) begin
                      ld_dropped = 1'b1;
                    end else begin
                      meta_we = 1'b1;
                      ws_nxt  = ws_inc;
                    end
                  end
                  CLS_FIRST:  spd0_nxt = cmd.speed_bits;
                  CLS_SECOND: spd1_nxt = cmd.speed_bits;
                  CLS_THIRD:  spd2_nxt = cmd.speed_bits;
                  default: ;
                endcase
              end
            end
            OP_POP: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                if (empty) begin
                  load_out = 1'b1;
                  ld_kind  = KIND_EMPTY;
                end else begin
                  rd_en        = 1'b1;
                  meta_rd      = 1'b1;
                  rd_slot      = rs_r;
                  rd_beat      = '0;
                  pop_slot_nxt = rs_r;
                  rs_nxt       = rs_inc;
                  k_nxt        = '0;
                  state_nxt    = S_POP;
                end
              end
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_kind  = KIND_BEAT;
          ld_id    = rd_meta_r.id;
          ld_len   = rd_meta_r.len;
          ld_word  = (k_r <= rd_meta_r.last) ? rd_word_r : '0;
          ld_last  = (k_r == BEAT_W'(BEATS_PER_FRAME - 1));
          if (ld_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en = 1'b1;
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Fill level after this step, low bits only
  assign ws_ext   = (SW + 1)'(ws_nxt);
  assign rs_ext   = (SW + 1)'(rs_nxt);
  assign fill_w   = (ws_ext >= rs_ext) ? ws_ext - rs_ext
                                       : ws_ext + (SW + 1)'(RING_DEPTH) - rs_ext;
  assign fill_ext = (SW + FILL_W)'(fill_w);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= '0;
      rs_r        <= '0;
      pop_slot_r  <= '0;
      k_r         <= '0;
      spd0_r      <= '0;
      spd1_r      <= '0;
      spd2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      rs_r        <= rs_nxt;
      pop_slot_r  <= pop_slot_nxt;
      k_r         <= k_nxt;
      spd0_r      <= spd0_nxt;
      spd1_r      <= spd1_nxt;
      spd2_r      <= spd2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r    <= ld_kind;
      out_id_r      <= ld_id;
      out_len_r     <= ld_len;
      out_word_r    <= ld_word;
      out_last_r    <= ld_last;
      out_dropped_r <= ld_dropped;
      out_fill_r    <= fill_ext[FILL_W-1:0];
    end
  end

  // Payload word memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[wr_addr] <= cmd.word;
    end
    if (rd_en) begin
      rd_word_r <= word_mem[rd_addr];
    end
  end

  // Entry header memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[ws_r] <= '{id: cmd.id, len: cmd.len, last: cmd.beat};
    end
    if (meta_rd) begin
      rd_meta_r <= meta_mem[rd_slot];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = out_kind_r;
  assign out_entry_id          = out_id_r;
  assign out_entry_len_code    = out_len_r;
  assign out_entry_word        = out_word_r;
  assign out_last_beat         = out_last_r;
  assign out_fill_count        = out_fill_r;
  assign out_frame_dropped     = out_dropped_r;
  assign out_speed_first_bits  = spd0_r;
  assign out_speed_second_bits = spd1_r;
  assign out_speed_third_bits  = spd2_r;

  `ASSERT_IMPLY(a_pop_holds_queue, clk, rst_n, state_r == S_POP, !cmd_ready)
  `ASSERT_NEXT(a_commit_not_empty, clk, rst_n, meta_we, ws_r != rs_r)
  `ASSERT_IMPLY(a_drop_only_full, clk, rst_n, load_out && ld_dropped, full && !meta_we)

endmodule

>>> design/can_rx_dispatch_ring_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_rx_dispatch_ring_top
// CAN receive dispatcher: speed message latches and a diagnostic frame ring.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : frame beats (in_req_type 0) or pop requests (in_req_type 1),
//           valid/ready. A frame ends on in_frame_end or its last beat slot.
//   out_* : results, valid/ready. A final beat gives one status item, a pop
//           gives BEATS_PER_FRAME beat items or one empty item.
//   cfg_* : register writes; the user writes only while the block idles, not
//           enforced by the block itself.
// Order: a taken item passes a queue slot, then the output register, before
//   its result is valid; a pop adds the ring memory read register between.
// Throughput: frame beats and status items run at one item per cycle while
//   no pop is in progress and the output is free; a pop holds off commands
//   to its last beat, the single ring read port giving one beat per cycle.
// Reset: ring empty, beat position zero, speed latches zero, registers at
//   their defaults. The ring needs no clearing pass.
// Stall: when out_ready is low the result is held; the four-entry command
//   queue keeps taking items until it fills, then in_ready drops.
// ----------------------------------------------------------------------------

module can_rx_dispatch_ring_top import crdr_pkg::*; #(
  parameter int RING_DEPTH      = 16,
  parameter int BEATS_PER_FRAME = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [ID_W-1:0]       in_frame_id,
  input  logic [LEN_W-1:0]      in_frame_len_code,
  input  logic [WORD_W-1:0]     in_frame_word,
  input  logic                  in_frame_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_result_kind,
  output logic [ID_W-1:0]       out_entry_id,
  output logic [LEN_W-1:0]      out_entry_len_code,
  output logic [WORD_W-1:0]     out_entry_word,
  output logic                  out_last_beat,
  output logic [FILL_W-1:0]     out_fill_count,
  output logic                  out_frame_dropped,
  output logic [SPEED_W-1:0]    out_speed_first_bits,
  output logic [SPEED_W-1:0]    out_speed_second_bits,
  output logic [SPEED_W-1:0]    out_speed_third_bits
);

  logic enq_valid, enq_ready, deq_valid, deq_ready;
  cmd_t enq_cmd, deq_cmd;

  // Front: accept and classify
  crdr_front #(
    .BEATS_PER_FRAME (BEATS_PER_FRAME)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_frame_id       (in_frame_id),
    .in_frame_len_code (in_frame_len_code),
    .in_frame_word     (in_frame_word),
    .in_frame_end      (in_frame_end),
    .enq_valid         (enq_valid),
    .enq_ready         (enq_ready),
    .enq_cmd           (enq_cmd)
  );

  // Command queue
  crdr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (enq_valid),
    .enq_ready (enq_ready),
    .enq_cmd   (enq_cmd),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_cmd   (deq_cmd)
  );

  // Back: ring, latches and results
  crdr_back #(
    .RING_DEPTH      (RING_DEPTH),
    .BEATS_PER_FRAME (BEATS_PER_FRAME)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd_valid             (deq_valid),
    .cmd_ready             (deq_ready),
    .cmd                   (deq_cmd),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_kind       (out_result_kind),
    .out_entry_id          (out_entry_id),
    .out_entry_len_code    (out_entry_len_code),
    .out_entry_word        (out_entry_word),
    .out_last_beat         (out_last_beat),
    .out_fill_count        (out_fill_count),
    .out_frame_dropped     (out_frame_dropped),
    .out_speed_first_bits  (out_speed_first_bits),
    .out_speed_second_bits (out_speed_second_bits),
    .out_speed_third_bits  (out_speed_third_bits)
  );

endmodule
